// ===== hw/rtl/xrs_pkg.sv =====
// ----------------------------------------------------------------------------
// xrs_pkg
// Shared types and constants for the xoshiro256++ random source.
// ----------------------------------------------------------------------------
package xrs_pkg;

  localparam int WORD_W     = 64;
  localparam int HALF_W     = 32;
  localparam int NUM_WORDS  = 4;
  localparam int IDX_W      = $clog2(NUM_WORDS);
  localparam int DIV_STEPS  = WORD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int OP_W       = 3;

  localparam logic [WORD_W-1:0] SM_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WORD_W-1:0] SM_MUL1   = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WORD_W-1:0] SM_MUL2   = 64'h94d0_49bb_1331_11eb;

  localparam int SM_SHIFT0  = 30;
  localparam int SM_SHIFT1  = 27;
  localparam int SM_SHIFT2  = 31;
  localparam int XO_ROT_OUT = 23;
  localparam int XO_SHL     = 17;
  localparam int XO_ROT_W3  = 45;
  localparam int FRAC53_SH  = 11;
  localparam int FRAC24_SH  = 40;

  typedef enum logic [OP_W-1:0] {
    OP_RAW    = 3'd0,
    OP_BIT    = 3'd1,
    OP_RANGE  = 3'd2,
    OP_FRAC53 = 3'd3,
    OP_FRAC24 = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_Z_STEP,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_MUL3,
    DP_MIX,
    DP_STORE,
    DP_EVAL,
    DP_ADVANCE,
    DP_DIV_STEP,
    DP_DIV_FIN
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_SEED_Z,
    ST_M1_0,
    ST_M1_1,
    ST_M1_2,
    ST_M1_3,
    ST_MIX,
    ST_M2_0,
    ST_M2_1,
    ST_M2_2,
    ST_M2_3,
    ST_STORE,
    ST_IDLE,
    ST_EVAL,
    ST_ADVANCE,
    ST_DIV,
    ST_DIV_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   mul_sel;   // 0: first SplitMix constant, 1: second
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic            range_bad;
    logic            word_last;
    logic            div_last;
  } dp_stat_t;

endpackage

// ===== hw/rtl/xrs_datapath.sv =====
// ----------------------------------------------------------------------------
// xrs_datapath
// State words, SplitMix64 seeding arithmetic, draw shaping, serial remainder
// unit and output register.
// ----------------------------------------------------------------------------
module xrs_datapath
  import xrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                seed_wen,
  input  logic [WORD_W-1:0]   seed_wdata,
  input  dp_cmd_t             cmd,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [WORD_W-1:0]   in_low,
  input  logic [WORD_W-1:0]   in_high,
  output dp_stat_t            stat,
  output logic [WORD_W-1:0]   out_value,
  output logic                out_error
);

  logic [WORD_W-1:0]   words [NUM_WORDS];
  logic [IDX_W-1:0]    idx;
  logic [WORD_W-1:0]   z;
  logic [WORD_W-1:0]   r;
  logic [WORD_W-1:0]   acc;
  logic [WORD_W-1:0]   prod;
  logic [OP_W-1:0]     operation;
  logic [WORD_W-1:0]   low;
  logic [WORD_W-1:0]   high;
  logic [WORD_W-1:0]   span;
  logic [WORD_W-1:0]   rem;
  logic [WORD_W-1:0]   quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W-1:0]   res_val;
  logic                res_err;

  logic [WORD_W-1:0]   z_next;
  logic [WORD_W-1:0]   mul_k;
  logic [HALF_W-1:0]   mul_a;
  logic [HALF_W-1:0]   mul_b;
  logic [WORD_W-1:0]   sum03;
  logic [WORD_W-1:0]   draw;
  logic [WORD_W-1:0]   shaped;
  logic [WORD_W:0]     rem_shift;
  logic [WORD_W:0]     rem_diff;
  logic                range_bad;
  logic [WORD_W-1:0]   w0_new;
  logic [WORD_W-1:0]   w1_new;
  logic [WORD_W-1:0]   w2_new;
  logic [WORD_W-1:0]   w3_new;

  assign z_next = z + SM_GOLDEN;
  assign mul_k  = cmd.mul_sel ? SM_MUL2 : SM_MUL1;
  assign mul_a  = (cmd.op == DP_MUL2) ? r[WORD_W-1:HALF_W] : r[HALF_W-1:0];
  assign mul_b  = (cmd.op == DP_MUL1) ? mul_k[WORD_W-1:HALF_W] : mul_k[HALF_W-1:0];

  // xoshiro256++ output and state transition
  assign sum03 = words[0] + words[3];
  assign draw  = {sum03[WORD_W-1-XO_ROT_OUT:0], sum03[WORD_W-1:WORD_W-XO_ROT_OUT]}
                 + words[0];

  always_comb begin
    logic [WORD_W-1:0] t2;
    logic [WORD_W-1:0] t3;
    t2     = words[2] ^ words[0];
    t3     = words[3] ^ words[1];
    w1_new = words[1] ^ t2;
    w0_new = words[0] ^ t3;
    w2_new = t2 ^ (words[1] << XO_SHL);
    w3_new = {t3[WORD_W-1-XO_ROT_W3:0], t3[WORD_W-1:WORD_W-XO_ROT_W3]};
  end

  always_comb begin
    case (op_t'(operation))
      OP_RAW:    shaped = draw;
      OP_BIT:    shaped = {{(WORD_W-1){1'b0}}, draw[0]};
      OP_FRAC53: shaped = draw >> FRAC53_SH;
      OP_FRAC24: shaped = draw >> FRAC24_SH;
      default:   shaped = '0;
    endcase
  end

  assign range_bad = $signed(low) >= $signed(high);

  // one restoring step of draw mod span
  assign rem_shift = {rem, quo[WORD_W-1]};
  assign rem_diff  = rem_shift - {1'b0, span};

  // control-side counters and seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      z   <= '0;
      idx <= '0;
      cnt <= '0;
    end else if (seed_wen) begin
      z   <= seed_wdata;
      idx <= '0;
    end else begin
      case (cmd.op)
        DP_Z_STEP:   z   <= z_next;
        DP_STORE:    idx <= idx + IDX_W'(1);
        DP_EVAL:     cnt <= '0;
        DP_DIV_STEP: cnt <= cnt + DIV_CNT_W'(1);
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_CAPTURE: begin
        operation <= in_operation;
        low       <= in_low;
        high      <= in_high;
      end
      DP_Z_STEP: r <= z_next ^ (z_next >> SM_SHIFT0);
      DP_MUL0:   prod <= WORD_W'(mul_a) * WORD_W'(mul_b);
      DP_MUL1: begin
        acc  <= prod;
        prod <= WORD_W'(mul_a) * WORD_W'(mul_b);
      end
      DP_MUL2: begin
        acc  <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        prod <= WORD_W'(mul_a) * WORD_W'(mul_b);
      end
      DP_MUL3:   r <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      DP_MIX:    r <= r ^ (r >> SM_SHIFT1);
      DP_STORE:  words[idx] <= r ^ (r >> SM_SHIFT2);
      DP_EVAL: begin
        span    <= high - low;
        rem     <= '0;
        res_val <= '0;
        res_err <= (op_t'(operation) == OP_RANGE) && range_bad;
      end
      DP_ADVANCE: begin
        words[0] <= w0_new;
        words[1] <= w1_new;
        words[2] <= w2_new;
        words[3] <= w3_new;
        quo      <= draw;
        res_val  <= shaped;
      end
      DP_DIV_STEP: begin
        quo <= quo << 1;
        if (!rem_diff[WORD_W]) begin
          rem <= rem_diff[WORD_W-1:0];
        end else begin
          rem <= rem_shift[WORD_W-1:0];
        end
      end
      DP_DIV_FIN: res_val <= low + rem;
      default:    ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value <= res_val;
      out_error <= res_err;
    end
  end

  assign stat.operation = operation;
  assign stat.range_bad = range_bad;
  assign stat.word_last = (idx == IDX_W'(NUM_WORDS - 1));
  assign stat.div_last  = &cnt;

endmodule

// ===== hw/rtl/xrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// xrs_ctrl
// Sequencer for seeding, draw, remainder iterations and result transfer.
// ----------------------------------------------------------------------------
module xrs_ctrl
  import xrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     seed_wen,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   skip;

  // unused codes and empty ranges produce a zero result without a draw
  always_comb begin
    case (op_t'(stat.operation))
      OP_RAW, OP_BIT, OP_FRAC53, OP_FRAC24: skip = 1'b0;
      OP_RANGE: skip = stat.range_bad;
      default:  skip = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SEED_Z;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    cmd.op       = DP_NOP;
    cmd.mul_sel  = 1'b0;
    cmd.out_load = 1'b0;
    s_tready     = 1'b0;
    case (state)
      ST_SEED_Z: begin
        cmd.op     = DP_Z_STEP;
        state_next = ST_M1_0;
      end
      ST_M1_0: begin
        cmd.op     = DP_MUL0;
        state_next = ST_M1_1;
      end
      ST_M1_1: begin
        cmd.op     = DP_MUL1;
        state_next = ST_M1_2;
      end
      ST_M1_2: begin
        cmd.op     = DP_MUL2;
        state_next = ST_M1_3;
      end
      ST_M1_3: begin
        cmd.op     = DP_MUL3;
        state_next = ST_MIX;
      end
      ST_MIX: begin
        cmd.op     = DP_MIX;
        state_next = ST_M2_0;
      end
      ST_M2_0: begin
        cmd.op      = DP_MUL0;
        cmd.mul_sel = 1'b1;
        state_next  = ST_M2_1;
      end
      ST_M2_1: begin
        cmd.op      = DP_MUL1;
        cmd.mul_sel = 1'b1;
        state_next  = ST_M2_2;
      end
      ST_M2_2: begin
        cmd.op      = DP_MUL2;
        cmd.mul_sel = 1'b1;
        state_next  = ST_M2_3;
      end
      ST_M2_3: begin
        cmd.op      = DP_MUL3;
        cmd.mul_sel = 1'b1;
        state_next  = ST_STORE;
      end
      ST_STORE: begin
        cmd.op     = DP_STORE;
        state_next = stat.word_last ? ST_IDLE : ST_SEED_Z;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op     = DP_CAPTURE;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.op     = DP_EVAL;
        state_next = skip ? ST_DONE : ST_ADVANCE;
      end
      ST_ADVANCE: begin
        cmd.op     = DP_ADVANCE;
        state_next = (op_t'(stat.operation) == OP_RANGE) ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (stat.div_last) begin
          state_next = ST_DIV_FIN;
        end
      end
      ST_DIV_FIN: begin
        cmd.op     = DP_DIV_FIN;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // a seed write restarts the expansion
    if (seed_wen) begin
      state_next   = ST_SEED_Z;
      cmd.op       = DP_NOP;
      cmd.out_load = 1'b0;
    end
  end

  assign m_tvalid = out_valid;

endmodule

// ===== hw/rtl/xoshiro_random_source.sv =====
// Raw, bit and fraction draws pass capture, evaluate and advance before the result register;
// range draws add a 64-step restoring remainder and a final add; unused codes and empty
// ranges skip the draw. A new request is taken only once the previous result is loaded.
// Reset and every seed write run a SplitMix64 expansion (z step, two multiplies, mix and
// store per word, one shared 32x32 multiplier), during which s_tready stays low.
// Reset is synchronous, active high, and seeds the generator from zero.
// ----------------------------------------------------------------------------
// xoshiro_random_source
// xoshiro256++ random source with raw, range, bit and fixed-point fraction draws.
// ----------------------------------------------------------------------------
module xoshiro_random_source
  import xrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                seed_wen,
  input  logic [WORD_W-1:0]   seed_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [2*WORD_W-1:0] s_tdata,   // low_bound [63:0], high_bound [127:64]
  input  logic [OP_W-1:0]     s_tuser,   // operation [2:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [WORD_W-1:0]   m_tdata,   // value [63:0]
  output logic                m_tuser    // range_error [0]
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  xrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .seed_wen (seed_wen),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  xrs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .seed_wen     (seed_wen),
    .seed_wdata   (seed_wdata),
    .cmd          (cmd),
    .in_operation (s_tuser),
    .in_low       (s_tdata[WORD_W-1:0]),
    .in_high      (s_tdata[2*WORD_W-1:WORD_W]),
    .stat         (stat),
    .out_value    (m_tdata),
    .out_error    (m_tuser)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the xoshiro256++ random source: a predictor of the
// generator state tracks every accepted request and seed write, and each
// result transfer is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------

import xrs_pkg::*;

typedef struct packed {
  logic [WORD_W-1:0] value;
  logic              range_error;
} draw_t;

class draw_tracker;
  localparam logic [63:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_A  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_B  = 64'h94d0_49bb_1331_11eb;

  logic [63:0] words [4];
  draw_t       pending_draws [$];
  int          mismatches;

  function new();
    mismatches = 0;
    reseed(64'd0);
  endfunction

  static function logic [63:0] rotl(logic [63:0] x, int k);
    return (x << k) | (x >> (64 - k));
  endfunction

  // SplitMix64 expansion of the seed into the four state words
  function void reseed(logic [63:0] seed_value);
    logic [63:0] z;
    logic [63:0] r;
    z = seed_value;
    for (int i = 0; i < 4; i++) begin
      z = z + GOLDEN;
      r = z;
      r = (r ^ (r >> 30)) * MIX_A;
      r = (r ^ (r >> 27)) * MIX_B;
      words[i] = r ^ (r >> 31);
    end
  endfunction

  function logic [63:0] next_draw();
    logic [63:0] result;
    logic [63:0] t;
    result = rotl(words[0] + words[3], 23) + words[0];
    t = words[1] << 17;
    words[2] ^= words[0];
    words[3] ^= words[1];
    words[1] ^= words[2];
    words[0] ^= words[3];
    words[2] ^= t;
    words[3] = rotl(words[3], 45);
    return result;
  endfunction

  function void note_request(logic [OP_W-1:0] op, logic [63:0] lo, logic [63:0] hi);
    draw_t d;
    d = '0;
    case (op)
      OP_RAW:    d.value = next_draw();
      OP_BIT:    d.value = next_draw() & 64'd1;
      OP_RANGE: begin
        if ($signed(lo) >= $signed(hi)) begin
          d.range_error = 1'b1;
        end else begin
          d.value = lo + next_draw() % (hi - lo);
        end
      end
      OP_FRAC53: d.value = next_draw() >> 11;
      OP_FRAC24: d.value = next_draw() >> 40;
      default:   d = '0;  // unused code: no advance, zero result
    endcase
    pending_draws.push_back(d);
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  function void check_draw(logic [63:0] value, logic err);
    draw_t d;
    if (pending_draws.size() == 0) begin
      report($sformatf("unexpected result value=%h range_error=%b", value, err));
    end else begin
      d = pending_draws.pop_front();
      if (value !== d.value)
        report($sformatf("value expected %h actual %h", d.value, value));
      if (err !== d.range_error)
        report($sformatf("range_error expected %b actual %b", d.range_error, err));
    end
  endfunction
endclass

module tb;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
  localparam int ITEMS_PER_PHASE = 275;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_CYCLES = 80;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                seed_wen = 1'b0;
  logic [WORD_W-1:0]   seed_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [2*WORD_W-1:0] s_tdata = '0;
  logic [OP_W-1:0]     s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [WORD_W-1:0]   m_tdata;
  logic                m_tuser;

  draw_tracker tracker = new();
  bit quiet = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;

  xoshiro_random_source dut (
    .clk       (clk),
    .rst       (rst),
    .seed_wen  (seed_wen),
    .seed_wdata(seed_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // result side: random stalls, check every transfer
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) tracker.check_draw(m_tdata, m_tuser);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        m_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [63:0] lo, logic [63:0] hi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {hi, lo};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(op, lo, hi);
  endtask

  task automatic write_seed(logic [63:0] value);
    s_tvalid <= 1'b0;
    while (tracker.pending_draws.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    seed_wen   <= 1'b1;
    seed_wdata <= value;
    @(posedge clk);
    tracker.reseed(value);
    seed_wen <= 1'b0;
  endtask

  task automatic random_bounds(output logic [63:0] lo, output logic [63:0] hi);
    case ($urandom_range(0, 5))
      0: begin
        lo = rand64();
        hi = rand64();
      end
      1: begin
        lo = 64'($signed($urandom_range(0, 2000)) - 1000);
        hi = lo + 64'($urandom_range(1, 100));
      end
      2: begin
        lo = rand64();
        hi = lo + (64'd1 << $urandom_range(0, 63));  // wraps into an error now and then
      end
      3: begin
        lo = rand64();
        hi = lo + (rand64() >> $urandom_range(0, 63));
      end
      4: begin
        lo = MIN64 + 64'($urandom_range(0, 15));
        hi = MAX64 - 64'($urandom_range(0, 15));
      end
      default: begin
        lo = rand64();
        hi = lo + 64'($urandom_range(0, 1));
      end
    endcase
  endtask

  task automatic random_phase(int count);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [OP_W-1:0] op;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_RANGE;
      else op = OP_W'($urandom_range(0, 4));
      if (op == OP_RANGE || $urandom_range(0, 1)) begin
        random_bounds(lo, hi);
      end else begin
        lo = rand64();
        hi = rand64();
      end
      send_request(op, lo, hi);
    end
  endtask

  initial begin
    logic [63:0] seeds [6];
    seeds = '{64'hffff_ffff_ffff_ffff, 64'd0, rand64(), 64'd1, rand64(), MIN64};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every operation, empty and inverted ranges, unused codes
    send_request(OP_RAW,    '0, '0);
    send_request(OP_RAW,    '1, '1);
    send_request(OP_BIT,    rand64(), rand64());
    send_request(OP_FRAC53, rand64(), rand64());
    send_request(OP_FRAC24, rand64(), rand64());
    send_request(OP_RANGE,  64'd0, 64'd1);
    send_request(OP_RANGE,  MIN64, MAX64);
    send_request(OP_RANGE,  MIN64, MIN64 + 64'd1);
    send_request(OP_RANGE,  MAX64 - 64'd1, MAX64);
    send_request(OP_RANGE,  -64'sd5, 64'sd5);
    send_request(OP_RANGE,  -64'sd1, 64'd0);
    send_request(OP_RANGE,  MIN64, 64'd0);
    send_request(OP_RANGE,  64'd0, MAX64);
    send_request(OP_RANGE,  64'd3, 64'd3);
    send_request(OP_RANGE,  MAX64, MIN64);
    send_request(OP_RANGE,  64'd0, '1);
    send_request(OP_RANGE,  MIN64, MIN64);
    send_request(3'd5,      rand64(), rand64());
    send_request(3'd6,      64'd0, 64'd1);
    send_request(3'd7,      '1, '1);
    send_request(OP_RAW,    rand64(), rand64());

    for (int p = 0; p < 6; p++) begin
      write_seed(seeds[p]);
      quiet = (p % 3 == 2);
      random_phase(ITEMS_PER_PHASE);
    end

    s_tvalid <= 1'b0;
    while (tracker.pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending_draws.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
